// ===== rtl/core/phi_pkg.sv =====
// phi_pkg: shared types, codes and constants of the piecewise hazard integrator
// used by phi_ctrl, phi_dp and piecewise_hazard_integrator_core; no dependencies
package phi_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int DIV_STEPS       = 72;

    localparam logic [2:0] REQ_LOAD    = 3'd0;
    localparam logic [2:0] REQ_RATE    = 3'd1;
    localparam logic [2:0] REQ_INTEG   = 3'd2;
    localparam logic [2:0] REQ_AVERAGE = 3'd3;
    localparam logic [2:0] REQ_INVERSE = 3'd4;

    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_BAD_LOAD = 3'd1;
    localparam logic [2:0] STS_EMPTY    = 3'd2;
    localparam logic [2:0] STS_REVERSED = 3'd3;
    localparam logic [2:0] STS_SAT      = 3'd4;

    localparam logic [39:0] MAX_Q40 = 40'hFF_FFFF_FFFF;
    localparam logic [39:0] MAX_T32 = 40'h00_FFFF_FFFF;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [3:0]  entry_index;
        logic [31:0] time_a;
        logic [31:0] time_b;
        logic [23:0] rate_value;
        logic [39:0] hazard_amount;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [39:0] result_value;
    } t_out_item;

    typedef enum logic [5:0] {
        OP_IDLE, OP_NOP, OP_ERR, OP_LD0, OP_LD_RD, OP_LD_MUL, OP_LD_WR,
        OP_SC_INIT, OP_SC_RD, OP_SC_CMP, OP_SAVE1, OP_RATE_RD, OP_RATE_OUT,
        OP_IE_RD, OP_IE_MUL, OP_IU_RD1, OP_IU_RD2, OP_IU_RD3, OP_IU_MUL2,
        OP_I_FIN, OP_AVG_LD, OP_DIV_RUN, OP_AVG_FIN, OP_INV_TOT, OP_INV_ZERO,
        OP_EXT_LD, OP_EXT_FIN, OP_J_INIT, OP_J_RD, OP_J_CMP, OP_J_DIR,
        OP_J_SAVE, OP_MD_A, OP_MD_M1, OP_MD_M2, OP_MD_FIN, OP_TMAX, OP_AMT0,
        OP_DONE
    } t_op;

    typedef enum logic [5:0] {
        ST_IDLE, ST_DISP, ST_ERR_BAD, ST_ERR_EMPTY, ST_ERR_REV, ST_LD0,
        ST_LD_RD, ST_LD_CHK, ST_LD_MUL, ST_LD_WR, ST_SC_INIT, ST_SC_RD,
        ST_SC_CMP, ST_SAVE1, ST_RATE_RD, ST_RATE_OUT, ST_I_BR, ST_IE_RD,
        ST_IE_MUL, ST_IU_RD1, ST_IU_RD2, ST_IU_RD3, ST_IU_MUL2, ST_I_FIN,
        ST_AVG_LD, ST_DIV_RUN, ST_AVG_FIN, ST_INV_TOT, ST_INV_CMP,
        ST_INV_ZERO, ST_EXT_LD, ST_EXT_FIN, ST_J_INIT, ST_J_RD, ST_J_CMP,
        ST_J_CHK, ST_J_DIR, ST_J_SAVE, ST_MD_A, ST_MD_M1, ST_MD_M2,
        ST_MD_FIN, ST_TMAX, ST_AMT0, ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        MODE_RATE, MODE_INT1, MODE_INT2, MODE_AVG, MODE_EXT, MODE_MD
    } t_mode;

    typedef struct packed {
        t_op        op;
        logic [2:0] code;
    } t_dp_cmd;

    typedef struct packed {
        logic       accepted;
        logic [2:0] req;
        logic       idx_zero;
        logic       ta_zero;
        logic       ld_ok;
        logic       ld_ta_lt;
        logic       cnt_zero;
        logic       tb_lt_ta;
        logic       t_eq;
        logic       amt_zero;
        logic       sc_end;
        logic       sc_hit;
        logic       seg_ge;
        logic       tot_gt;
        logic       rt_zero;
        logic       j_hit;
        logic       j_direct;
        logic       div_done;
        logic       out_free;
    } t_dp_stat;

endpackage

// ===== rtl/core/phi_ctrl.sv =====
// phi_ctrl: sequencer of the piecewise hazard integrator
// depends on phi_pkg; drives phi_dp through t_dp_cmd, reads t_dp_stat
module phi_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  phi_pkg::t_dp_stat i_stat,
    output phi_pkg::t_dp_cmd  o_cmd
);

    phi_pkg::t_state r_state, n_state;
    phi_pkg::t_mode  r_mode, n_mode;
    phi_pkg::t_state w_ret_sc, w_ret_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= phi_pkg::ST_IDLE;
            r_mode  <= phi_pkg::MODE_RATE;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
        end
    end

    // return points of the shared scan and divider
    always_comb begin
        unique case (r_mode)
            phi_pkg::MODE_RATE: w_ret_sc = phi_pkg::ST_RATE_RD;
            phi_pkg::MODE_INT1: w_ret_sc = phi_pkg::ST_SAVE1;
            default:            w_ret_sc = phi_pkg::ST_I_BR;
        endcase
        unique case (r_mode)
            phi_pkg::MODE_AVG: w_ret_div = phi_pkg::ST_AVG_FIN;
            phi_pkg::MODE_EXT: w_ret_div = phi_pkg::ST_EXT_FIN;
            default:           w_ret_div = phi_pkg::ST_MD_FIN;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        unique case (r_state)
            phi_pkg::ST_IDLE: if (i_stat.accepted) n_state = phi_pkg::ST_DISP;
            phi_pkg::ST_DISP: begin
                if (i_stat.req == phi_pkg::REQ_LOAD) begin
                    if (i_stat.idx_zero)
                        n_state = i_stat.ta_zero ? phi_pkg::ST_LD0 : phi_pkg::ST_ERR_BAD;
                    else
                        n_state = i_stat.ld_ok ? phi_pkg::ST_LD_RD : phi_pkg::ST_ERR_BAD;
                end else if (i_stat.req > phi_pkg::REQ_INVERSE) begin
                    n_state = phi_pkg::ST_ERR_BAD;
                end else if (i_stat.cnt_zero) begin
                    n_state = phi_pkg::ST_ERR_EMPTY;
                end else if (i_stat.req == phi_pkg::REQ_RATE) begin
                    n_state = phi_pkg::ST_SC_INIT;
                    n_mode  = phi_pkg::MODE_RATE;
                end else if (i_stat.req == phi_pkg::REQ_INVERSE) begin
                    n_state = i_stat.amt_zero ? phi_pkg::ST_AMT0 : phi_pkg::ST_SC_INIT;
                    n_mode  = phi_pkg::MODE_INT1;
                end else if (i_stat.tb_lt_ta) begin
                    n_state = phi_pkg::ST_ERR_REV;
                end else begin
                    n_state = phi_pkg::ST_SC_INIT;
                    n_mode  = (i_stat.req == phi_pkg::REQ_AVERAGE && i_stat.t_eq) ?
                              phi_pkg::MODE_RATE : phi_pkg::MODE_INT1;
                end
            end
            phi_pkg::ST_ERR_BAD:   n_state = phi_pkg::ST_DONE;
            phi_pkg::ST_ERR_EMPTY: n_state = phi_pkg::ST_DONE;
            phi_pkg::ST_ERR_REV:   n_state = phi_pkg::ST_DONE;
            phi_pkg::ST_LD0:       n_state = phi_pkg::ST_DONE;
            phi_pkg::ST_LD_RD:     n_state = phi_pkg::ST_LD_CHK;
            phi_pkg::ST_LD_CHK:
                n_state = i_stat.ld_ta_lt ? phi_pkg::ST_ERR_BAD : phi_pkg::ST_LD_MUL;
            phi_pkg::ST_LD_MUL:    n_state = phi_pkg::ST_LD_WR;
            phi_pkg::ST_LD_WR:     n_state = phi_pkg::ST_DONE;
            phi_pkg::ST_SC_INIT:   n_state = phi_pkg::ST_SC_RD;
            phi_pkg::ST_SC_RD:
                n_state = i_stat.sc_end ? w_ret_sc : phi_pkg::ST_SC_CMP;
            phi_pkg::ST_SC_CMP:
                n_state = i_stat.sc_hit ? w_ret_sc : phi_pkg::ST_SC_RD;
            phi_pkg::ST_SAVE1: begin
                n_state = phi_pkg::ST_SC_RD;
                n_mode  = phi_pkg::MODE_INT2;
            end
            phi_pkg::ST_RATE_RD:   n_state = phi_pkg::ST_RATE_OUT;
            phi_pkg::ST_RATE_OUT:  n_state = phi_pkg::ST_DONE;
            phi_pkg::ST_I_BR:
                n_state = i_stat.seg_ge ? phi_pkg::ST_IE_RD : phi_pkg::ST_IU_RD1;
            phi_pkg::ST_IE_RD:     n_state = phi_pkg::ST_IE_MUL;
            phi_pkg::ST_IE_MUL:    n_state = phi_pkg::ST_I_FIN;
            phi_pkg::ST_IU_RD1:    n_state = phi_pkg::ST_IU_RD2;
            phi_pkg::ST_IU_RD2:    n_state = phi_pkg::ST_IU_RD3;
            phi_pkg::ST_IU_RD3:    n_state = phi_pkg::ST_IU_MUL2;
            phi_pkg::ST_IU_MUL2:   n_state = phi_pkg::ST_I_FIN;
            phi_pkg::ST_I_FIN: begin
                if (i_stat.req == phi_pkg::REQ_INTEG) begin
                    n_state = phi_pkg::ST_DONE;
                end else if (i_stat.req == phi_pkg::REQ_AVERAGE) begin
                    n_state = phi_pkg::ST_AVG_LD;
                    n_mode  = phi_pkg::MODE_AVG;
                end else begin
                    n_state = phi_pkg::ST_INV_TOT;
                end
            end
            phi_pkg::ST_AVG_LD:    n_state = phi_pkg::ST_DIV_RUN;
            phi_pkg::ST_DIV_RUN:   if (i_stat.div_done) n_state = w_ret_div;
            phi_pkg::ST_AVG_FIN:   n_state = phi_pkg::ST_DONE;
            phi_pkg::ST_INV_TOT:   n_state = phi_pkg::ST_INV_CMP;
            phi_pkg::ST_INV_CMP: begin
                if (!i_stat.tot_gt) begin
                    n_state = phi_pkg::ST_J_INIT;
                end else if (i_stat.rt_zero) begin
                    n_state = phi_pkg::ST_INV_ZERO;
                end else begin
                    n_state = phi_pkg::ST_EXT_LD;
                    n_mode  = phi_pkg::MODE_EXT;
                end
            end
            phi_pkg::ST_INV_ZERO:  n_state = phi_pkg::ST_DONE;
            phi_pkg::ST_EXT_LD:    n_state = phi_pkg::ST_DIV_RUN;
            phi_pkg::ST_EXT_FIN:   n_state = phi_pkg::ST_TMAX;
            phi_pkg::ST_J_INIT:    n_state = phi_pkg::ST_J_RD;
            phi_pkg::ST_J_RD:      n_state = phi_pkg::ST_J_CMP;
            phi_pkg::ST_J_CMP:
                n_state = i_stat.j_hit ? phi_pkg::ST_J_CHK : phi_pkg::ST_J_RD;
            phi_pkg::ST_J_CHK:
                n_state = i_stat.j_direct ? phi_pkg::ST_J_DIR : phi_pkg::ST_J_SAVE;
            phi_pkg::ST_J_DIR:     n_state = phi_pkg::ST_TMAX;
            phi_pkg::ST_J_SAVE:    n_state = phi_pkg::ST_MD_A;
            phi_pkg::ST_MD_A:      n_state = phi_pkg::ST_MD_M1;
            phi_pkg::ST_MD_M1:     n_state = phi_pkg::ST_MD_M2;
            phi_pkg::ST_MD_M2: begin
                n_state = phi_pkg::ST_DIV_RUN;
                n_mode  = phi_pkg::MODE_MD;
            end
            phi_pkg::ST_MD_FIN:    n_state = phi_pkg::ST_TMAX;
            phi_pkg::ST_TMAX:      n_state = phi_pkg::ST_DONE;
            phi_pkg::ST_AMT0:      n_state = phi_pkg::ST_DONE;
            phi_pkg::ST_DONE:      if (i_stat.out_free) n_state = phi_pkg::ST_IDLE;
            default:               n_state = phi_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.code = phi_pkg::STS_OK;
        unique case (r_state)
            phi_pkg::ST_IDLE:      o_cmd.op = phi_pkg::OP_IDLE;
            phi_pkg::ST_ERR_BAD: begin
                o_cmd.op   = phi_pkg::OP_ERR;
                o_cmd.code = phi_pkg::STS_BAD_LOAD;
            end
            phi_pkg::ST_ERR_EMPTY: begin
                o_cmd.op   = phi_pkg::OP_ERR;
                o_cmd.code = phi_pkg::STS_EMPTY;
            end
            phi_pkg::ST_ERR_REV: begin
                o_cmd.op   = phi_pkg::OP_ERR;
                o_cmd.code = phi_pkg::STS_REVERSED;
            end
            phi_pkg::ST_LD0:       o_cmd.op = phi_pkg::OP_LD0;
            phi_pkg::ST_LD_RD:     o_cmd.op = phi_pkg::OP_LD_RD;
            phi_pkg::ST_LD_MUL:    o_cmd.op = phi_pkg::OP_LD_MUL;
            phi_pkg::ST_LD_WR:     o_cmd.op = phi_pkg::OP_LD_WR;
            phi_pkg::ST_SC_INIT:   o_cmd.op = phi_pkg::OP_SC_INIT;
            phi_pkg::ST_SC_RD:     o_cmd.op = phi_pkg::OP_SC_RD;
            phi_pkg::ST_SC_CMP:    o_cmd.op = phi_pkg::OP_SC_CMP;
            phi_pkg::ST_SAVE1:     o_cmd.op = phi_pkg::OP_SAVE1;
            phi_pkg::ST_RATE_RD:   o_cmd.op = phi_pkg::OP_RATE_RD;
            phi_pkg::ST_RATE_OUT:  o_cmd.op = phi_pkg::OP_RATE_OUT;
            phi_pkg::ST_IE_RD:     o_cmd.op = phi_pkg::OP_IE_RD;
            phi_pkg::ST_IE_MUL:    o_cmd.op = phi_pkg::OP_IE_MUL;
            phi_pkg::ST_IU_RD1:    o_cmd.op = phi_pkg::OP_IU_RD1;
            phi_pkg::ST_IU_RD2:    o_cmd.op = phi_pkg::OP_IU_RD2;
            phi_pkg::ST_IU_RD3:    o_cmd.op = phi_pkg::OP_IU_RD3;
            phi_pkg::ST_IU_MUL2:   o_cmd.op = phi_pkg::OP_IU_MUL2;
            phi_pkg::ST_I_FIN:     o_cmd.op = phi_pkg::OP_I_FIN;
            phi_pkg::ST_AVG_LD:    o_cmd.op = phi_pkg::OP_AVG_LD;
            phi_pkg::ST_DIV_RUN:   o_cmd.op = phi_pkg::OP_DIV_RUN;
            phi_pkg::ST_AVG_FIN:   o_cmd.op = phi_pkg::OP_AVG_FIN;
            phi_pkg::ST_INV_TOT:   o_cmd.op = phi_pkg::OP_INV_TOT;
            phi_pkg::ST_INV_ZERO:  o_cmd.op = phi_pkg::OP_INV_ZERO;
            phi_pkg::ST_EXT_LD:    o_cmd.op = phi_pkg::OP_EXT_LD;
            phi_pkg::ST_EXT_FIN:   o_cmd.op = phi_pkg::OP_EXT_FIN;
            phi_pkg::ST_J_INIT:    o_cmd.op = phi_pkg::OP_J_INIT;
            phi_pkg::ST_J_RD:      o_cmd.op = phi_pkg::OP_J_RD;
            phi_pkg::ST_J_CMP:     o_cmd.op = phi_pkg::OP_J_CMP;
            phi_pkg::ST_J_DIR:     o_cmd.op = phi_pkg::OP_J_DIR;
            phi_pkg::ST_J_SAVE:    o_cmd.op = phi_pkg::OP_J_SAVE;
            phi_pkg::ST_MD_A:      o_cmd.op = phi_pkg::OP_MD_A;
            phi_pkg::ST_MD_M1:     o_cmd.op = phi_pkg::OP_MD_M1;
            phi_pkg::ST_MD_M2:     o_cmd.op = phi_pkg::OP_MD_M2;
            phi_pkg::ST_MD_FIN:    o_cmd.op = phi_pkg::OP_MD_FIN;
            phi_pkg::ST_TMAX:      o_cmd.op = phi_pkg::OP_TMAX;
            phi_pkg::ST_AMT0:      o_cmd.op = phi_pkg::OP_AMT0;
            phi_pkg::ST_DONE:      o_cmd.op = phi_pkg::OP_DONE;
            default:               o_cmd.op = phi_pkg::OP_NOP;
        endcase
    end

endmodule

// ===== rtl/core/phi_dp.sv =====
// phi_dp: table memories, shared multiplier, restoring divider and i/o registers
// depends on phi_pkg; sequenced by phi_ctrl
module phi_dp #(
    parameter int MAX_ENTRIES = phi_pkg::MAX_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  phi_pkg::t_dp_cmd  i_cmd,
    output phi_pkg::t_dp_stat o_stat,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  phi_pkg::t_in_item i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output phi_pkg::t_out_item o_out_item
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int IW = (CW > 5) ? CW : 5;
    localparam int DW = phi_pkg::DIV_STEPS;

    logic [31:0] mem_bt [MAX_ENTRIES];
    logic [23:0] mem_rt [MAX_ENTRIES];
    logic [39:0] mem_ch [MAX_ENTRIES];

    phi_pkg::t_in_item r_in, n_in;
    logic [31:0] r_qa, n_qa, r_qb, n_qb, r_tsc, n_tsc, r_bt1, n_bt1, r_ma, n_ma;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [IW-1:0] r_i, n_i, r_seg, n_seg, r_seg1, n_seg1;
    logic [39:0] r_c1, n_c1, r_mb, n_mb, r_val, n_val, r_dvs, n_dvs, r_rem, n_rem;
    logic [71:0] r_part, n_part, r_dvd, n_dvd, r_quo, n_quo;
    logic [40:0] r_acc, n_acc, r_tot, n_tot;
    logic        r_sat, n_sat, r_oval, n_oval;
    logic [2:0]  r_status, n_status;
    logic [6:0]  r_dcnt, n_dcnt;
    phi_pkg::t_out_item r_out, n_out;
    logic [31:0] r_rd_bt;
    logic [23:0] r_rd_rt;
    logic [39:0] r_rd_ch;

    logic          rd_en, wr_en;
    logic [IW-1:0] rd_idx, wr_idx, w_idx, w_cnt, w_last;
    logic [31:0]   wr_bt;
    logic [23:0]   wr_rt;
    logic [39:0]   wr_ch;
    logic [31:0]   m_x, m_y;
    logic [63:0]   m_p;
    logic          accept, out_free;
    logic [40:0]   rem_sh;
    logic          div_ge;
    logic [41:0]   i_sum;
    logic [40:0]   ld_c;
    logic [72:0]   ext_t;

    assign w_idx  = IW'(r_in.entry_index);
    assign w_cnt  = IW'(r_cnt);
    assign w_last = w_cnt - IW'(1);
    assign o_in_ready  = (i_cmd.op == phi_pkg::OP_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign out_free    = !r_oval || i_out_ready;
    assign o_out_valid = r_oval;
    assign o_out_item  = r_out;

    assign m_p    = m_x * m_y;
    assign rem_sh = {r_rem, r_dvd[71]};
    assign div_ge = rem_sh >= {1'b0, r_dvs};
    assign i_sum  = {1'b0, r_part[56:16]} + {1'b0, r_acc};
    assign ld_c   = {1'b0, r_rd_ch} + {1'b0, r_part[55:16]};
    assign ext_t  = {41'd0, r_rd_bt} + {1'b0, r_quo};

    always_comb begin
        o_stat.accepted = accept;
        o_stat.req      = r_in.req_type;
        o_stat.idx_zero = (r_in.entry_index == 4'd0);
        o_stat.ta_zero  = (r_in.time_a == 32'd0);
        o_stat.ld_ok    = (w_idx == w_cnt) && (w_idx < IW'(MAX_ENTRIES));
        o_stat.ld_ta_lt = (r_in.time_a < r_rd_bt);
        o_stat.cnt_zero = (r_cnt == '0);
        o_stat.tb_lt_ta = (r_in.time_b < r_in.time_a);
        o_stat.t_eq     = (r_in.time_b == r_in.time_a);
        o_stat.amt_zero = (r_in.hazard_amount == 40'd0);
        o_stat.sc_end   = (r_i <= IW'(1));
        o_stat.sc_hit   = (r_rd_bt <= r_tsc);
        o_stat.seg_ge   = (r_seg1 >= r_seg);
        o_stat.tot_gt   = (r_tot > {1'b0, r_rd_ch});
        o_stat.rt_zero  = (r_rd_rt == 24'd0);
        o_stat.j_hit    = ({1'b0, r_rd_ch} >= r_tot) || (r_i == w_last);
        o_stat.j_direct = ({1'b0, r_rd_ch} == r_tot) || (r_i == '0);
        o_stat.div_done = (r_dcnt == 7'd1);
        o_stat.out_free = out_free;
    end

    // shared multiplier operands
    always_comb begin
        m_x = {8'd0, r_rd_rt};
        m_y = 32'd0;
        unique case (i_cmd.op)
            phi_pkg::OP_LD_MUL:  m_y = r_in.time_a - r_rd_bt;
            phi_pkg::OP_IE_MUL:  m_y = r_qb - r_qa;
            phi_pkg::OP_IU_RD3:  m_y = r_bt1 - r_qa;
            phi_pkg::OP_IU_MUL2: m_y = r_qb - r_rd_bt;
            phi_pkg::OP_MD_M1: begin
                m_x = r_ma;
                m_y = r_mb[31:0];
            end
            phi_pkg::OP_MD_M2: begin
                m_x = r_ma;
                m_y = {24'd0, r_mb[39:32]};
            end
            default: m_y = 32'd0;
        endcase
    end

    always_comb begin
        n_in = r_in;   n_qa = r_qa;     n_qb = r_qb;     n_tsc = r_tsc;
        n_bt1 = r_bt1; n_ma = r_ma;     n_cnt = r_cnt;   n_i = r_i;
        n_seg = r_seg; n_seg1 = r_seg1; n_c1 = r_c1;     n_mb = r_mb;
        n_val = r_val; n_dvs = r_dvs;   n_rem = r_rem;   n_part = r_part;
        n_dvd = r_dvd; n_quo = r_quo;   n_acc = r_acc;   n_tot = r_tot;
        n_sat = r_sat; n_status = r_status; n_dcnt = r_dcnt;
        n_out = r_out;
        n_oval = r_oval && !i_out_ready;
        rd_en = 1'b0;  rd_idx = '0;
        wr_en = 1'b0;  wr_idx = '0;
        wr_bt = r_in.time_a; wr_rt = r_in.rate_value; wr_ch = 40'd0;
        unique case (i_cmd.op)
            phi_pkg::OP_IDLE: begin
                if (accept) begin
                    n_in  = i_in_item;
                    n_sat = 1'b0;
                    n_qa  = (i_in_item.req_type == phi_pkg::REQ_INVERSE) ?
                            32'd0 : i_in_item.time_a;
                    n_qb  = (i_in_item.req_type == phi_pkg::REQ_INVERSE) ?
                            i_in_item.time_a : i_in_item.time_b;
                end
            end
            phi_pkg::OP_ERR: begin
                n_val    = 40'd0;
                n_status = i_cmd.code;
            end
            phi_pkg::OP_LD0: begin
                wr_en    = 1'b1;
                wr_bt    = 32'd0;
                n_cnt    = CW'(1);
                n_val    = 40'd0;
                n_status = phi_pkg::STS_OK;
            end
            phi_pkg::OP_LD_RD: begin
                rd_en  = 1'b1;
                rd_idx = w_idx - IW'(1);
            end
            phi_pkg::OP_LD_MUL: n_part = {8'd0, m_p};
            phi_pkg::OP_LD_WR: begin
                wr_en    = 1'b1;
                wr_idx   = w_idx;
                wr_ch    = ld_c[40] ? phi_pkg::MAX_Q40 : ld_c[39:0];
                n_cnt    = CW'(w_idx + IW'(1));
                n_val    = wr_ch;
                n_status = ld_c[40] ? phi_pkg::STS_SAT : phi_pkg::STS_OK;
            end
            phi_pkg::OP_SC_INIT: begin
                n_tsc = r_qa;
                n_i   = w_cnt;
            end
            phi_pkg::OP_SC_RD: begin
                if (r_i <= IW'(1)) begin
                    n_seg = '0;
                end else begin
                    rd_en  = 1'b1;
                    rd_idx = r_i - IW'(1);
                end
            end
            phi_pkg::OP_SC_CMP: begin
                if (r_rd_bt <= r_tsc) n_seg = r_i - IW'(1);
                else                  n_i   = r_i - IW'(1);
            end
            phi_pkg::OP_SAVE1: begin
                n_seg1 = r_seg;
                n_tsc  = r_qb;
                n_i    = w_cnt;
            end
            phi_pkg::OP_RATE_RD: begin
                rd_en  = 1'b1;
                rd_idx = r_seg;
            end
            phi_pkg::OP_RATE_OUT: begin
                n_val    = {16'd0, r_rd_rt};
                n_status = phi_pkg::STS_OK;
            end
            phi_pkg::OP_IE_RD: begin
                rd_en  = 1'b1;
                rd_idx = r_seg1;
            end
            phi_pkg::OP_IE_MUL: begin
                n_part = {8'd0, m_p};
                n_acc  = 41'd0;
            end
            phi_pkg::OP_IU_RD1: begin
                rd_en  = 1'b1;
                rd_idx = r_seg1 + IW'(1);
            end
            phi_pkg::OP_IU_RD2: begin
                n_bt1  = r_rd_bt;
                n_c1   = r_rd_ch;
                rd_en  = 1'b1;
                rd_idx = r_seg1;
            end
            phi_pkg::OP_IU_RD3: begin
                n_part = {8'd0, m_p};
                rd_en  = 1'b1;
                rd_idx = r_seg;
            end
            phi_pkg::OP_IU_MUL2: begin
                n_part = r_part + {8'd0, m_p};
                n_acc  = {1'b0, r_rd_ch - r_c1};
            end
            phi_pkg::OP_I_FIN: begin
                if (i_sum[41:40] != 2'd0) begin
                    n_val = phi_pkg::MAX_Q40;
                    n_sat = 1'b1;
                end else begin
                    n_val = i_sum[39:0];
                end
                n_status = (r_sat || i_sum[41:40] != 2'd0) ?
                           phi_pkg::STS_SAT : phi_pkg::STS_OK;
            end
            phi_pkg::OP_AVG_LD: begin
                n_dvd  = {16'd0, r_val, 16'd0};
                n_dvs  = {8'd0, r_qb - r_qa};
                n_rem  = 40'd0;
                n_dcnt = 7'(DW);
            end
            phi_pkg::OP_DIV_RUN: begin
                n_rem  = div_ge ? 40'(rem_sh - {1'b0, r_dvs}) : rem_sh[39:0];
                n_quo  = {r_quo[70:0], div_ge};
                n_dvd  = {r_dvd[70:0], 1'b0};
                n_dcnt = r_dcnt - 7'd1;
            end
            phi_pkg::OP_AVG_FIN: begin
                if (r_quo[71:40] != '0) begin
                    n_val    = phi_pkg::MAX_Q40;
                    n_status = phi_pkg::STS_SAT;
                end else begin
                    n_val    = r_quo[39:0];
                    n_status = r_sat ? phi_pkg::STS_SAT : phi_pkg::STS_OK;
                end
            end
            phi_pkg::OP_INV_TOT: begin
                n_tot  = {1'b0, r_val} + {1'b0, r_in.hazard_amount};
                rd_en  = 1'b1;
                rd_idx = w_last;
            end
            phi_pkg::OP_INV_ZERO: begin
                n_val    = phi_pkg::MAX_T32;
                n_status = phi_pkg::STS_SAT;
            end
            phi_pkg::OP_EXT_LD: begin
                n_dvd  = {15'd0, r_tot - {1'b0, r_rd_ch}, 16'd0};
                n_dvs  = {16'd0, r_rd_rt};
                n_rem  = 40'd0;
                n_dcnt = 7'(DW);
            end
            phi_pkg::OP_EXT_FIN: begin
                if (ext_t[72:32] != '0) begin
                    n_val = phi_pkg::MAX_T32;
                    n_sat = 1'b1;
                end else begin
                    n_val = {8'd0, ext_t[31:0]};
                end
            end
            phi_pkg::OP_J_INIT: n_i = '0;
            phi_pkg::OP_J_RD: begin
                rd_en  = 1'b1;
                rd_idx = r_i;
            end
            phi_pkg::OP_J_CMP: begin
                if (!(({1'b0, r_rd_ch} >= r_tot) || (r_i == w_last))) n_i = r_i + IW'(1);
            end
            phi_pkg::OP_J_DIR: n_val = {8'd0, r_rd_bt};
            phi_pkg::OP_J_SAVE: begin
                n_bt1  = r_rd_bt;
                n_c1   = r_rd_ch;
                rd_en  = 1'b1;
                rd_idx = r_i - IW'(1);
            end
            phi_pkg::OP_MD_A: begin
                n_ma  = r_bt1 - r_rd_bt;
                n_mb  = r_tot[39:0] - r_rd_ch;
                n_dvs = r_c1 - r_rd_ch;
            end
            phi_pkg::OP_MD_M1: n_part = {8'd0, m_p};
            phi_pkg::OP_MD_M2: begin
                n_dvd  = r_part + {m_p[39:0], 32'd0};
                n_rem  = 40'd0;
                n_dcnt = 7'(DW);
            end
            phi_pkg::OP_MD_FIN: n_val = {8'd0, r_rd_bt + r_quo[31:0]};
            phi_pkg::OP_TMAX: begin
                if (r_val < {8'd0, r_qb}) n_val = {8'd0, r_qb};
                n_status = r_sat ? phi_pkg::STS_SAT : phi_pkg::STS_OK;
            end
            phi_pkg::OP_AMT0: begin
                n_val    = {8'd0, r_in.time_a};
                n_status = phi_pkg::STS_OK;
            end
            phi_pkg::OP_DONE: begin
                if (out_free) begin
                    n_oval             = 1'b1;
                    n_out.status       = r_status;
                    n_out.result_value = r_val;
                end
            end
            default: n_oval = r_oval && !i_out_ready;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_oval <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_oval <= n_oval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in <= n_in;   r_qa <= n_qa;     r_qb <= n_qb;     r_tsc <= n_tsc;
        r_bt1 <= n_bt1; r_ma <= n_ma;     r_i <= n_i;       r_seg <= n_seg;
        r_seg1 <= n_seg1; r_c1 <= n_c1;   r_mb <= n_mb;     r_val <= n_val;
        r_dvs <= n_dvs; r_rem <= n_rem;   r_part <= n_part; r_dvd <= n_dvd;
        r_quo <= n_quo; r_acc <= n_acc;   r_tot <= n_tot;   r_sat <= n_sat;
        r_status <= n_status; r_dcnt <= n_dcnt; r_out <= n_out;
    end

    // table memories: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_bt[wr_idx[AW-1:0]] <= wr_bt;
            mem_rt[wr_idx[AW-1:0]] <= wr_rt;
            mem_ch[wr_idx[AW-1:0]] <= wr_ch;
        end
        if (rd_en) begin
            r_rd_bt <= mem_bt[rd_idx[AW-1:0]];
            r_rd_rt <= mem_rt[rd_idx[AW-1:0]];
            r_rd_ch <= mem_ch[rd_idx[AW-1:0]];
        end
    end

endmodule

// ===== rtl/core/piecewise_hazard_integrator_core.sv =====
// a load writes one table entry; a rate query scans the table backward entry by entry;
// an integral takes two backward table scans, and an average adds the 72-step
// restoring divider; an inverse adds a forward scan, the multiply steps and the divider
// where needed
// one item at a time: the next item is taken the cycle after the result is registered,
// even while that result waits; synchronous active-low reset clears count, sequencer, valid
module piecewise_hazard_integrator_core #(
    parameter int MAX_ENTRIES = phi_pkg::MAX_ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  phi_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output phi_pkg::t_out_item o_out_item
);

    // command and status between sequencer and datapath
    phi_pkg::t_dp_cmd  w_cmd;
    phi_pkg::t_dp_stat w_stat;

    // sequencer: dispatch, table scans, divider hand-off
    phi_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // datapath: tables, shared multiplier, divider, item registers
    phi_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
